FILE: design/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg: shared types and constants for the sliding window top-k sum block
// Register indexes, default sizes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
package swk_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 7;
	localparam int CFG_INDEX_BITS  = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_COUNT  = 1'b1;

	localparam logic [CFG_BITS-1:0] WINDOW_LEN_RST = 7'd64;
	localparam logic [CFG_BITS-1:0] TOP_COUNT_RST  = 7'd1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_RANK   = 5'b00010,
		ST_SELECT = 5'b00100,
		ST_SUM    = 5'b01000,
		ST_EMIT   = 5'b10000
	} seq_state_t;

	// control word broadcast to every cell of the chain
	typedef struct packed {
		logic shift;     // new sample enters, probes reload, counts clear
		logic rank;      // compare against passing probe, then rotate
		logic load_sum;  // reload probes with values and selection flags
		logic sum;       // rotate probes toward the accumulator
	} cell_ctrl_t;

endpackage

FILE: design/swk_cell.sv
// ----------------------------------------------------------------------------
// swk_cell: one window position of the ranking chain
// Holds the sample of one age, a rotating probe and a count of probes that
// outrank the held sample; the count decides membership in the top set.
// ----------------------------------------------------------------------------
module swk_cell #(
	parameter int IDX         = 0,
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF,
	parameter int IDX_BITS    = 6,
	parameter int CNT_BITS    = 7
) (
	input  logic                          clk,
	input  swk_pkg::cell_ctrl_t           ctrl,
	input  logic [CNT_BITS-1:0]           win_len,
	input  logic [CNT_BITS-1:0]           top_k,
	input  logic signed [SAMPLE_BITS-1:0] shift_in,
	output logic signed [SAMPLE_BITS-1:0] shift_out,
	input  logic signed [SAMPLE_BITS-1:0] probe_val_in,
	input  logic [IDX_BITS-1:0]           probe_tag_in,
	input  logic                          probe_sel_in,
	output logic signed [SAMPLE_BITS-1:0] probe_val_out,
	output logic [IDX_BITS-1:0]           probe_tag_out,
	output logic                          probe_sel_out
);

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic signed [SAMPLE_BITS-1:0] p_val_q;
	logic [IDX_BITS-1:0]           p_tag_q;
	logic                          p_sel_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          in_window;
	logic                          probe_in_window;
	logic                          beats;

	assign in_window       = CNT_BITS'(IDX) < win_len;
	assign probe_in_window = CNT_BITS'(p_tag_q) < win_len;
	// ties go to the younger sample
	assign beats = (p_val_q > val_q) ||
		((p_val_q == val_q) && (p_tag_q < IDX_BITS'(IDX)));

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q   <= shift_in;
			p_val_q <= shift_in;
			p_tag_q <= IDX_BITS'(IDX);
			cnt_q   <= '0;
		end else if (ctrl.rank) begin
			if (beats && probe_in_window && in_window) begin
				cnt_q <= cnt_q + 1'b1;
			end
			p_val_q <= probe_val_in;
			p_tag_q <= probe_tag_in;
		end else if (ctrl.load_sum) begin
			p_val_q <= val_q;
			p_sel_q <= in_window && (cnt_q < top_k);
		end else if (ctrl.sum) begin
			p_val_q <= probe_val_in;
			p_sel_q <= probe_sel_in;
		end
	end

	assign shift_out     = val_q;
	assign probe_val_out = p_val_q;
	assign probe_tag_out = p_tag_q;
	assign probe_sel_out = p_sel_q;

endmodule

FILE: design/sliding_window_top_k_sum_max_top.sv
// ----------------------------------------------------------------------------
// sliding_window_top_k_sum_max_top: sliding window top-k sum with running max
// Samples shift through a chain of cells; a probe ring ranks every window
// sample, then the selected samples rotate into one accumulator.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   sample, start_req
//  out      output     out_valid / out_stall window_full, top_sum, best_sum
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// a word that fills the window runs the rank steps, the select step and the sum steps,
// and its result loads from the emit step; a word before the window is full goes
// straight from idle to the emit step, and the next word is taken back in idle
// one word is in work at a time; in_stall is low only while idle
// a finished result waits in the output register while the next word is taken;
// a stalled full output register holds the sequencer in its emit step
// reset clears sequencer, fill count, best-sum valid flag and output valid
// ----------------------------------------------------------------------------
module sliding_window_top_k_sum_max_top #(
	parameter int WINDOW_MAX  = swk_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_BITS   = $clog2(WINDOW_MAX),
	localparam int CNT_BITS   = $clog2(WINDOW_MAX + 1),
	localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  start_req,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  window_full,
	output logic signed [SUM_BITS-1:0]            top_sum,
	output logic signed [SUM_BITS-1:0]            best_sum,
	input  logic                                  cfg_we,
	input  logic [swk_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [swk_pkg::CFG_BITS-1:0]          cfg_data
);

	swk_pkg::seq_state_t           state_q;
	swk_pkg::cell_ctrl_t           ctrl;
	logic [swk_pkg::CFG_BITS-1:0]  window_len_q;
	logic [swk_pkg::CFG_BITS-1:0]  top_count_q;
	logic [31:0]                   wl_ext;
	logic [31:0]                   tc_ext;
	logic [31:0]                   w_sat;
	logic [31:0]                   k_lo;
	logic [CNT_BITS-1:0]           w_eff;
	logic [CNT_BITS-1:0]           k_eff;
	logic [CNT_BITS-1:0]           fill_q;
	logic [CNT_BITS-1:0]           fill_next;
	logic [IDX_BITS-1:0]           step_q;
	logic                          step_last;
	logic                          full_q;
	logic signed [SUM_BITS-1:0]    acc_q;
	logic signed [SUM_BITS-1:0]    best_q;
	logic                          best_valid_q;
	logic signed [SUM_BITS-1:0]    best_new;
	logic                          in_acc;
	logic                          out_load;
	logic                          out_valid_q;
	logic                          window_full_q;
	logic signed [SUM_BITS-1:0]    top_sum_q;
	logic signed [SUM_BITS-1:0]    best_sum_q;

	logic signed [SAMPLE_BITS-1:0] cell_val   [0:WINDOW_MAX-1];
	logic signed [SAMPLE_BITS-1:0] probe_val  [0:WINDOW_MAX-1];
	logic [IDX_BITS-1:0]           probe_tag  [0:WINDOW_MAX-1];
	logic                          probe_sel  [0:WINDOW_MAX-1];

	// effective window and top count
	assign wl_ext = 32'(window_len_q);
	assign tc_ext = 32'(top_count_q);
	assign w_sat  = (wl_ext == 32'd0) ? 32'd1 :
		(wl_ext > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : wl_ext;
	assign k_lo   = (tc_ext == 32'd0) ? 32'd1 : tc_ext;
	assign w_eff  = CNT_BITS'(w_sat);
	assign k_eff  = (k_lo > w_sat) ? CNT_BITS'(w_sat) : CNT_BITS'(k_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swk_pkg::WINDOW_LEN_RST;
			top_count_q  <= swk_pkg::TOP_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				swk_pkg::REG_WINDOW_LEN: window_len_q <= cfg_data;
				swk_pkg::REG_TOP_COUNT:  top_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != swk_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign step_last = (step_q == IDX_BITS'(WINDOW_MAX - 1));
	assign out_load  = (state_q == swk_pkg::ST_EMIT) && (!out_valid_q || !out_stall);

	assign fill_next = start_req ? CNT_BITS'(1) :
		(fill_q < CNT_BITS'(WINDOW_MAX)) ? fill_q + 1'b1 : fill_q;

	assign best_new = (!best_valid_q || (acc_q > best_q)) ? acc_q : best_q;

	always_comb begin
		ctrl          = '0;
		ctrl.shift    = in_acc;
		ctrl.rank     = (state_q == swk_pkg::ST_RANK);
		ctrl.load_sum = (state_q == swk_pkg::ST_SELECT);
		ctrl.sum      = (state_q == swk_pkg::ST_SUM);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= swk_pkg::ST_IDLE;
			step_q       <= '0;
			fill_q       <= '0;
			full_q       <= 1'b0;
			best_valid_q <= 1'b0;
		end else begin
			case (state_q)
				swk_pkg::ST_IDLE: begin
					if (in_acc) begin
						fill_q <= fill_next;
						full_q <= (fill_next >= w_eff);
						step_q <= '0;
						if (start_req) begin
							best_valid_q <= 1'b0;
						end
						state_q <= (fill_next >= w_eff) ? swk_pkg::ST_RANK : swk_pkg::ST_EMIT;
					end
				end
				swk_pkg::ST_RANK: begin
					step_q <= step_q + 1'b1;
					if (step_last) begin
						state_q <= swk_pkg::ST_SELECT;
					end
				end
				swk_pkg::ST_SELECT: begin
					step_q  <= '0;
					state_q <= swk_pkg::ST_SUM;
				end
				swk_pkg::ST_SUM: begin
					step_q <= step_q + 1'b1;
					if (step_last) begin
						state_q <= swk_pkg::ST_EMIT;
					end
				end
				swk_pkg::ST_EMIT: begin
					if (out_load) begin
						if (full_q) begin
							best_valid_q <= 1'b1;
						end
						state_q <= swk_pkg::ST_IDLE;
					end
				end
				default: state_q <= swk_pkg::ST_IDLE;
			endcase
		end
	end

	// accumulator and best sum
	always_ff @(posedge clk) begin
		if (in_acc || ctrl.load_sum) begin
			acc_q <= '0;
		end else if (ctrl.sum && probe_sel[WINDOW_MAX-1]) begin
			acc_q <= acc_q + SUM_BITS'(probe_val[WINDOW_MAX-1]);
		end
		if (out_load && full_q) begin
			best_q <= best_new;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			window_full_q <= full_q;
			top_sum_q     <= full_q ? acc_q : '0;
			best_sum_q    <= full_q ? best_new : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_full = window_full_q;
	assign top_sum     = top_sum_q;
	assign best_sum    = best_sum_q;

	// chain of cells; probes form a ring over all positions
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		localparam int PREV = (i + WINDOW_MAX - 1) % WINDOW_MAX;
		swk_cell #(
			.IDX         (i),
			.SAMPLE_BITS (SAMPLE_BITS),
			.IDX_BITS    (IDX_BITS),
			.CNT_BITS    (CNT_BITS)
		) u_cell (
			.clk           (clk),
			.ctrl          (ctrl),
			.win_len       (w_eff),
			.top_k         (k_eff),
			.shift_in      ((i == 0) ? sample : cell_val[PREV]),
			.shift_out     (cell_val[i]),
			.probe_val_in  (probe_val[PREV]),
			.probe_tag_in  (probe_tag[PREV]),
			.probe_sel_in  (probe_sel[PREV]),
			.probe_val_out (probe_val[i]),
			.probe_tag_out (probe_tag[i]),
			.probe_sel_out (probe_sel[i])
		);
	end

	// checks
	a_not_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !window_full) |-> (top_sum == '0) && (best_sum == '0))
		else $error("result before full window carries nonzero sums");

	a_best_ge_top: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && window_full) |-> (best_sum >= top_sum))
		else $error("best sum below current top sum");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result load did not raise out_valid");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(WINDOW_MAX))
		else $error("fill count beyond window capacity");

endmodule

FILE: dv/sliding_window_top_k_sum_max_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_top_k_sum_max_checker: result checker for the top-k window sum
// Watches the config port and both word channels, keeps its own window of
// samples, works out the expected top-k sum and running best for every
// accepted sample and compares them field by field with the result words.
// ----------------------------------------------------------------------------
module sliding_window_top_k_sum_max_checker #(
	parameter int WINDOW_MAX  = swk_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF,
	localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic                               start_req,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic                               window_full,
	input  logic signed [SUM_BITS-1:0]         top_sum,
	input  logic signed [SUM_BITS-1:0]         best_sum,
	input  logic                               cfg_we,
	input  logic [swk_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [swk_pkg::CFG_BITS-1:0]       cfg_data,
	output int                                 fail_count,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       full;
		logic signed [SUM_BITS-1:0] top;
		logic signed [SUM_BITS-1:0] best;
	} window_result_t;

	window_result_t sums_due[$];

	logic signed [SAMPLE_BITS-1:0] hist [WINDOW_MAX];
	int                            head;
	int                            taken;
	longint                        best_seen;
	bit                            best_set;
	logic [swk_pkg::CFG_BITS-1:0]  len_reg;
	logic [swk_pkg::CFG_BITS-1:0]  count_reg;

	// push one sample into the window and work out the result word it causes
	function automatic window_result_t absorb_sample(logic signed [SAMPLE_BITS-1:0] s,
			logic restart);
		longint         ranked [WINDOW_MAX];
		longint         held;
		longint         acc;
		int             span;
		int             pick;
		int             j;
		window_result_t r;

		r = '0;
		if (restart) begin
			head = 0;
			taken = 0;
			best_seen = 0;
			best_set = 1'b0;
		end
		hist[head] = s;
		head = (head + 1) % WINDOW_MAX;
		if (taken < WINDOW_MAX)
			taken++;

		span = (len_reg == 0) ? 1 : ((len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(len_reg));
		if (taken < span)
			return r;
		pick = (count_reg == 0) ? 1 : int'(count_reg);
		if (pick > span)
			pick = span;

		// newest first, then sort largest first
		for (int n = 0; n < span; n++)
			ranked[n] = hist[(head + WINDOW_MAX - 1 - n) % WINDOW_MAX];
		for (int i = 1; i < span; i++) begin
			held = ranked[i];
			j = i;
			while (j > 0 && ranked[j-1] < held) begin
				ranked[j] = ranked[j-1];
				j--;
			end
			ranked[j] = held;
		end
		acc = 0;
		for (int i = 0; i < pick; i++)
			acc += ranked[i];

		// first full window sets the best outright, even when negative
		if (!best_set || acc > best_seen) begin
			best_seen = acc;
			best_set = 1'b1;
		end
		r.full = 1'b1;
		r.top  = acc[SUM_BITS-1:0];
		r.best = best_seen[SUM_BITS-1:0];
		return r;
	endfunction

	task automatic check_field(input string field, input logic signed [SUM_BITS-1:0] want,
			input logic signed [SUM_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_result_t due;

		if (!arst_n) begin
			sums_due.delete();
			head = 0;
			taken = 0;
			best_seen = 0;
			best_set = 1'b0;
			len_reg = swk_pkg::WINDOW_LEN_RST;
			count_reg = swk_pkg::TOP_COUNT_RST;
			fail_count = 0;
			pending = 0;
		end else begin
			// results come from older words, so retire before taking the new one
			if (out_valid && !out_stall) begin
				if (sums_due.size() == 0) begin
					$error("result word with no sample waiting: full %0b top %0d best %0d",
						window_full, top_sum, best_sum);
					fail_count++;
				end else begin
					due = sums_due.pop_front();
					check_field("window_full", SUM_BITS'(due.full), SUM_BITS'(window_full));
					check_field("top_sum", due.top, top_sum);
					check_field("best_sum", due.best, best_sum);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					swk_pkg::REG_WINDOW_LEN: len_reg = cfg_data;
					swk_pkg::REG_TOP_COUNT:  count_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				sums_due.push_back(absorb_sample(sample, start_req));
			pending = sums_due.size();
		end
	end

endmodule

FILE: dv/tb_sliding_window_top_k_sum_max_top.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_top_k_sum_max_top: testbench for the top-k window sum block
// Drives sample words in random bursts, stalls the result side on its own
// pattern and steps through window and top-count settings between phases.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sliding_window_top_k_sum_max_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW_MAX  = swk_pkg::WINDOW_MAX_DEF;
	localparam int SAMPLE_BITS = swk_pkg::SAMPLE_BITS_DEF;
	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE      = 8;
	localparam int TAIL_CYCLES = 2 * WINDOW_MAX + 2;
	localparam int PHASES      = 14;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic                               in_stall;
	logic signed [SAMPLE_BITS-1:0]      sample    = '0;
	logic                               start_req = 1'b0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic                               window_full;
	logic signed [SUM_BITS-1:0]         top_sum;
	logic signed [SUM_BITS-1:0]         best_sum;
	logic                               cfg_we    = 1'b0;
	logic [swk_pkg::CFG_INDEX_BITS-1:0] cfg_index = swk_pkg::REG_WINDOW_LEN;
	logic [swk_pkg::CFG_BITS-1:0]       cfg_data  = '0;

	int fail_count;
	int pending;
	int burst_left = 0;
	int stall_mode = 0;
	int mode_left  = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	sliding_window_top_k_sum_max_top #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.start_req   (start_req),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_full (window_full),
		.top_sum     (top_sum),
		.best_sum    (best_sum),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	sliding_window_top_k_sum_max_checker #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.start_req   (start_req),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.window_full (window_full),
		.top_sum     (top_sum),
		.best_sum    (best_sum),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// result side: free, random, mostly free, or long stall blocks
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 400);
		end
		mode_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= ($urandom_range(0, 7) == 0);
			default: out_stall <= ((mode_left % 64) < 40);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: return S_MAX;
					1: return S_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return SAMPLE_BITS'(int'($urandom_range(0, 40)) - 20);
			3: return SAMPLE_BITS'(int'($urandom_range(0, 3)) * 1000 - 1500);
			4: return S_MAX - SAMPLE_BITS'($urandom_range(0, 3));
			5: return S_MIN + SAMPLE_BITS'($urandom_range(0, 3));
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// one sample word; valid stays up afterwards unless a gap or drain lowers it
	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input logic restart);
		int gap;

		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 6);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		sample    <= s;
		start_req <= restart;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [swk_pkg::CFG_BITS-1:0] len,
			input logic [swk_pkg::CFG_BITS-1:0] cnt);
		cfg_we    <= 1'b1;
		cfg_index <= swk_pkg::REG_WINDOW_LEN;
		cfg_data  <= len;
		@(posedge clk);
		cfg_index <= swk_pkg::REG_TOP_COUNT;
		cfg_data  <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [swk_pkg::CFG_BITS-1:0] len_plan [PHASES];
		logic [swk_pkg::CFG_BITS-1:0] cnt_plan [PHASES];
		int                           items;
		logic                         lead_restart;

		len_plan = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd7, 7'd64, 7'd3, 7'd33, 7'd64,
			7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
		cnt_plan = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd100, 7'd1, 7'd0, 7'd17, 7'd127,
			7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
		for (int p = 9; p < PHASES; p++) begin
			len_plan[p] = swk_pkg::CFG_BITS'($urandom_range(1, 64));
			cnt_plan[p] = swk_pkg::CFG_BITS'($urandom_range(0, 70));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, window not yet full
		send_word(S_MAX, 1'b1);
		send_word(S_MIN, 1'b0);
		send_word('0, 1'b0);
		drain();

		// small window: all-negative window, extremes, ties, restart
		write_cfg(7'd4, 7'd2);
		repeat (4) send_word(S_MIN, 1'b0);
		send_word(S_MAX, 1'b0);
		send_word(S_MAX, 1'b0);
		send_word('0, 1'b0);
		send_word('1, 1'b0);
		repeat (4) send_word(32'sd5, 1'b0);
		send_word(32'sd7, 1'b1);
		send_word(32'sd1, 1'b0);
		send_word(32'sd2, 1'b0);
		send_word(32'sd3, 1'b0);
		drain();

		// zero lengths act as one
		write_cfg(7'd0, 7'd0);
		send_word(-32'sd5, 1'b0);
		send_word(32'sd9, 1'b0);
		send_word(-32'sd1, 1'b0);
		drain();

		// top count beyond the window
		write_cfg(7'd2, 7'd9);
		send_word(S_MIN, 1'b0);
		send_word(32'sd11, 1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_cfg(len_plan[p], cnt_plan[p]);
			items = $urandom_range(120, 150);
			// some phases keep the running window across the setting change
			lead_restart = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < items; n++) begin
				if ((p == 2 && n == items / 2) || $urandom_range(0, 399) == 0)
					drain();
				send_word(pick_sample(), (n == 0 && lead_restart) || $urandom_range(0, 149) == 0);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
